// ----- rtl/core/lzrw_pkg.sv -----
package lzrw_pkg;

  // Window geometry
  localparam int unsigned WinDepth = 4096;
  localparam int unsigned PtrW     = 12;
  localparam int unsigned FillW    = PtrW + 1;

  // Seed pattern region boundaries
  localparam logic [PtrW-1:0] SeedRampEnd  = 12'h0FF;
  localparam logic [PtrW-1:0] SeedDescEnd  = 12'h1FF;
  localparam logic [PtrW-1:0] SeedQuadBase = 12'h200;
  localparam logic [PtrW-1:0] SeedQuadEnd  = 12'h600;

  // Command byte fields
  localparam logic [7:0] CmdHighMask = 8'hF0;

  // Input opcodes
  localparam logic OP_STREAM  = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WRITE
  } state_e;

  typedef enum logic [1:0] {
    PH_CMD = 2'd0,
    PH_LIT = 2'd1,
    PH_REF = 2'd2
  } phase_e;

  // Window content straight after reset or restart, as a function of address.
  function automatic logic [7:0] seed_byte(input logic [PtrW-1:0] addr);
    logic [PtrW-1:0] diff;
    diff = addr - SeedQuadBase;
    if (addr <= SeedRampEnd) begin
      seed_byte = addr[7:0];
    end else if (addr <= SeedDescEnd) begin
      seed_byte = ~addr[7:0];
    end else if (addr < SeedQuadEnd) begin
      seed_byte = diff[9:2];
    end else begin
      seed_byte = addr[7:0];
    end
  endfunction

endpackage

// ----- rtl/core/lz_ring_window_decompressor_core.sv -----
// Channel | Direction | Handshake              | Payload
// in      | sink      | in_valid_i / in_stall_o  | opcode_i, data_byte_i
// out     | source    | out_valid_o / out_stall_i | out_byte_o, last_of_burst_o
//
// A command byte or a restart gives no result. A literal loads the output
// register. A back-reference low byte starts a copy of n bytes (3 to 17):
// each byte takes a registered window read and then a write-back.
// Reset and restart take effect at once: a fill count marks which window entries
// were written since then, and unwritten entries read as the seed pattern.
// A stalled output holds the copy sequencer in its write step; the input is stalled
// whenever a copy is running or the output register cannot take a new byte.
module lz_ring_window_decompressor_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       opcode_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_burst_o
);

  import lzrw_pkg::*;

  // Sequencer and decoder state
  state_e            state_q, state_d;
  phase_e            phase_q, phase_d;
  logic [PtrW-1:0]   wp_q, wp_d;
  logic [PtrW-1:0]   cp_q, cp_d;
  logic [4:0]        run_q, run_d;
  logic [3:0]        nib_q, nib_d;
  logic [FillW-1:0]  fill_q, fill_d;

  // Output register
  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_byte_q, out_byte_d;
  logic              out_last_q, out_last_d;

  // Window memory and its registered read path
  logic [7:0]        mem [WinDepth];
  logic [7:0]        rdata_q;
  logic [7:0]        seed_q;
  logic              hit_q;
  logic              mem_we;
  logic [7:0]        mem_wdata;
  logic [7:0]        copy_byte;

  logic              out_free;
  logic              in_xfer;
  logic              rd_hit;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign in_xfer    = in_valid_i && !in_stall_o;

  // An entry counts as written once the write pointer has passed it since the last
  // restart; the pointer starts at zero, so the written entries are always a prefix.
  assign rd_hit    = fill_q[PtrW] || (cp_q < fill_q[PtrW-1:0]);
  assign copy_byte = hit_q ? rdata_q : seed_q;

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign last_of_burst_o = out_last_q;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    wp_d        = wp_q;
    cp_d        = cp_q;
    run_d       = run_q;
    nib_d       = nib_q;
    fill_d      = fill_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    mem_we      = 1'b0;
    mem_wdata   = data_byte_i;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (opcode_i == OP_RESTART) begin
            wp_d    = '0;
            cp_d    = '0;
            run_d   = '0;
            nib_d   = '0;
            fill_d  = '0;
            phase_d = PH_CMD;
          end else begin
            unique case (phase_q)
              PH_LIT: begin
                // Literal goes straight to the window and the output register.
                mem_we      = 1'b1;
                mem_wdata   = data_byte_i;
                wp_d        = wp_q + 1'b1;
                fill_d      = fill_q + {{(FillW-1){1'b0}}, !fill_q[PtrW]};
                out_valid_d = 1'b1;
                out_byte_d  = data_byte_i;
                out_last_d  = 1'b1;
                if (run_q <= 5'd1) begin
                  run_d   = '0;
                  phase_d = PH_CMD;
                end else begin
                  run_d = run_q - 5'd1;
                end
              end
              PH_REF: begin
                cp_d = {nib_q, data_byte_i};
                if (run_q != 5'd0) begin
                  state_d = ST_READ;
                end else begin
                  phase_d = PH_CMD;
                end
              end
              default: begin
                // Command byte: a zero high nibble opens a literal run.
                if ((data_byte_i & CmdHighMask) == 8'h00) begin
                  run_d   = {1'b0, data_byte_i[3:0]} + 5'd1;
                  phase_d = PH_LIT;
                end else begin
                  nib_d   = data_byte_i[3:0];
                  run_d   = {1'b0, data_byte_i[7:4]} + 5'd2;
                  phase_d = PH_REF;
                end
              end
            endcase
          end
        end
      end

      ST_READ: begin
        // The window read at the copy pointer is registered in this cycle.
        state_d = ST_WRITE;
      end

      ST_WRITE: begin
        if (out_free) begin
          mem_we      = 1'b1;
          mem_wdata   = copy_byte;
          wp_d        = wp_q + 1'b1;
          fill_d      = fill_q + {{(FillW-1){1'b0}}, !fill_q[PtrW]};
          cp_d        = cp_q + 1'b1;
          out_valid_d = 1'b1;
          out_byte_d  = copy_byte;
          out_last_d  = (run_q == 5'd1);
          if (run_q == 5'd1) begin
            run_d   = '0;
            phase_d = PH_CMD;
            state_d = ST_IDLE;
          end else begin
            run_d   = run_q - 5'd1;
            state_d = ST_READ;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_CMD;
      wp_q        <= '0;
      cp_q        <= '0;
      run_q       <= '0;
      nib_q       <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      wp_q        <= wp_d;
      cp_q        <= cp_d;
      run_q       <= run_d;
      nib_q       <= nib_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers and the window memory need no reset.
  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    if (mem_we) begin
      mem[wp_q] <= mem_wdata;
    end
    rdata_q <= mem[cp_q];
    seed_q  <= seed_byte(cp_q);
    hit_q   <= rd_hit;
  end

endmodule

// ----- dv/lz_ring_window_decompressor_core_test.sv -----
module lz_ring_window_decompressor_core_test;
  import lzrw_pkg::*;

  // One decompressed byte as it leaves the block.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  // One row of the directed stream. Where typed is set, the burst length and
  // the first byte of the burst are written out by hand and must agree with
  // the decoder model as well as with the block.
  typedef struct packed {
    logic       op;
    logic [7:0] data;
    logic       typed;
    logic [4:0] n_exp;
    logic [7:0] first_exp;
  } stim_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic       opcode_i;
  logic [7:0] data_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] out_byte_o;
  logic       last_of_burst_o;

  lz_ring_window_decompressor_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .last_of_burst_o(last_of_burst_o)
  );

  // Decoder model state: its own copy of the window, the write pointer and
  // the parse state of the compressed stream.
  logic [7:0]  window_m [0:4095];
  logic [11:0] wr_ptr_m;
  phase_e      phase_m;
  int unsigned run_left_m;
  logic [3:0]  ref_hi_m;

  // Bytes that the block still owes us, oldest first.
  out_beat_t   pending_bytes [$];
  int          mismatches;
  bit          sender_calm;
  bit          sink_calm;
  stim_row_t   directed_rows [0:25];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: far beyond the slowest legal run, even with every burst at its
  // longest and every output transfer held off by the longest stall.
  initial begin
    #6000000;
    $display("** lz_ring_window_decompressor_core: FAILED **");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  // Window content after reset or restart: a rising ramp, a falling ramp,
  // each value four times over, and then the low byte of the address.
  function automatic logic [7:0] window_seed(input logic [11:0] addr);
    logic [11:0] off;
    off = addr - 12'h200;
    if (addr < 12'h100) begin
      return addr[7:0];
    end else if (addr < 12'h200) begin
      return 8'hFF - addr[7:0];
    end else if (addr < 12'h600) begin
      return off[9:2];
    end else begin
      return addr[7:0];
    end
  endfunction

  task automatic restart_decoder();
    for (int a = 0; a < 4096; a++) begin
      window_m[a] = window_seed(a[11:0]);
    end
    wr_ptr_m   = '0;
    phase_m    = PH_CMD;
    run_left_m = 0;
    ref_hi_m   = '0;
  endtask

  task automatic emit_byte(input logic [7:0] value, input logic last);
    out_beat_t beat;
    beat.data = value;
    beat.last = last;
    window_m[wr_ptr_m] = value;
    wr_ptr_m = wr_ptr_m + 12'd1;
    pending_bytes.push_back(beat);
  endtask

  // Advances the decoder model by one accepted input transfer and queues the
  // bytes that it should produce.
  task automatic decode_transfer(input logic op, input logic [7:0] b,
                                 output int n_bytes, output logic [7:0] first_byte);
    logic [11:0] rd_ptr;
    logic [7:0]  value;
    n_bytes    = 0;
    first_byte = 8'h00;
    if (op == OP_RESTART) begin
      restart_decoder();
    end else begin
      case (phase_m)
        PH_LIT: begin
          emit_byte(b, 1'b1);
          n_bytes    = 1;
          first_byte = b;
          if (run_left_m <= 1) begin
            run_left_m = 0;
            phase_m    = PH_CMD;
          end else begin
            run_left_m--;
          end
        end
        PH_REF: begin
          // The copy may overlap its own output, so each byte is read after
          // the previous one has been written back.
          rd_ptr = {ref_hi_m, b};
          while (run_left_m > 0 && n_bytes < 17) begin
            value = window_m[rd_ptr];
            rd_ptr = rd_ptr + 12'd1;
            emit_byte(value, run_left_m == 1);
            if (n_bytes == 0) begin
              first_byte = value;
            end
            n_bytes++;
            run_left_m--;
          end
          run_left_m = 0;
          phase_m    = PH_CMD;
        end
        default: begin
          // A command byte: literal run when the high nibble is clear,
          // otherwise the first half of a back-reference.
          if ((b & CmdHighMask) == 8'h00) begin
            run_left_m = b[3:0] + 1;
            phase_m    = PH_LIT;
          end else begin
            ref_hi_m   = b[3:0];
            run_left_m = b[7:4] + 2;
            phase_m    = PH_REF;
          end
        end
      endcase
    end
  endtask

  function automatic int sender_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (sender_calm || roll < 65) begin
      return 0;
    end else if (roll < 95) begin
      return $urandom_range(1, 3);
    end else begin
      return $urandom_range(8, 30);
    end
  endfunction

  // Offers one input transfer, waits for it to be taken and feeds the model.
  // Entered and left at a falling edge; valid is only ever lowered in a step
  // where it is not raised again.
  task automatic send_byte(input logic op, input logic [7:0] b,
                           output int n_bytes, output logic [7:0] first_byte);
    int gap;
    if ($urandom_range(0, 39) == 0) begin
      sender_calm = !sender_calm;
    end
    gap = sender_gap();
    if (gap > 0) begin
      in_valid_i  <= 1'b0;
      opcode_i    <= 1'($urandom);
      data_byte_i <= 8'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    opcode_i    <= op;
    data_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    decode_transfer(op, b, n_bytes, first_byte);
    @(negedge clk_i);
  endtask

  // Holds the input idle until every queued byte has come out.
  task automatic drain_output();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_bytes.size() != 0);
  endtask

  // Output side: random stalls, mostly short, now and then long, with calm
  // stretches in which no new output stall is started.
  initial begin : output_stall_driver
    int hold;
    hold        = 0;
    sink_calm   = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 149) == 0) begin
        sink_calm = !sink_calm;
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        hold--;
      end else if (!sink_calm && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Every output transfer is compared with the oldest byte still owed.
  initial begin : output_checker
    out_beat_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        if (pending_bytes.size() == 0) begin
          report_mismatch("output byte with none owed", out_byte_o, 0);
        end else begin
          want = pending_bytes.pop_front();
          if (out_byte_o !== want.data) begin
            report_mismatch("out_byte_o", out_byte_o, want.data);
          end
          if (last_of_burst_o !== want.last) begin
            report_mismatch("last_of_burst_o", last_of_burst_o, want.last);
          end
        end
      end
    end
  end

  initial begin : stream_driver
    int          n_bytes;
    logic [7:0]  first_byte;
    int          stream_items;
    int          roll;
    int          lit_tokens;
    int          run_len;
    logic [3:0]  hi;
    logic [11:0] pos;
    bit          paused;

    mismatches   = 0;
    sender_calm  = 1'b0;
    stream_items = 0;
    lit_tokens   = 0;
    paused       = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    opcode_i     = OP_STREAM;
    data_byte_i  = 8'h00;
    restart_decoder();

    // Directed stream: shortest and longest copies, copies from every seed
    // region, a copy that wraps past the top of the window, a run-length
    // style copy that overlaps its own output, the extreme data bytes, and
    // restarts that cut into a literal run and into a back-reference.
    directed_rows = '{
      '{OP_RESTART, 8'hFF, 1'b1, 5'd0,  8'h00},
      '{OP_STREAM,  8'h10, 1'b1, 5'd0,  8'h00},
      '{OP_STREAM,  8'h00, 1'b1, 5'd3,  8'h00},
      '{OP_STREAM,  8'hF1, 1'b1, 5'd0,  8'h00},
      '{OP_STREAM,  8'hFF, 1'b0, 5'd0,  8'h00},
      '{OP_STREAM,  8'h00, 1'b1, 5'd0,  8'h00},
      '{OP_STREAM,  8'hFF, 1'b1, 5'd1,  8'hFF},
      '{OP_STREAM,  8'h1F, 1'b1, 5'd0,  8'h00},
      '{OP_STREAM,  8'hFF, 1'b1, 5'd3,  8'hFF},
      '{OP_STREAM,  8'h02, 1'b1, 5'd0,  8'h00},
      '{OP_STREAM,  8'h5A, 1'b1, 5'd1,  8'h5A},
      '{OP_RESTART, 8'h00, 1'b1, 5'd0,  8'h00},
      '{OP_STREAM,  8'h00, 1'b1, 5'd0,  8'h00},
      '{OP_STREAM,  8'hA5, 1'b1, 5'd1,  8'hA5},
      '{OP_STREAM,  8'h20, 1'b1, 5'd0,  8'h00},
      '{OP_STREAM,  8'h00, 1'b1, 5'd4,  8'hA5},
      '{OP_STREAM,  8'h35, 1'b1, 5'd0,  8'h00},
      '{OP_RESTART, 8'h5A, 1'b1, 5'd0,  8'h00},
      '{OP_STREAM,  8'h41, 1'b1, 5'd0,  8'h00},
      '{OP_STREAM,  8'h80, 1'b1, 5'd6,  8'h7F},
      '{OP_STREAM,  8'h73, 1'b1, 5'd0,  8'h00},
      '{OP_STREAM,  8'h10, 1'b0, 5'd0,  8'h00},
      '{OP_STREAM,  8'hA6, 1'b1, 5'd0,  8'h00},
      '{OP_STREAM,  8'h34, 1'b1, 5'd12, 8'h34},
      '{OP_STREAM,  8'hFF, 1'b1, 5'd0,  8'h00},
      '{OP_STREAM,  8'h00, 1'b1, 5'd17, 8'h00}
    };

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].op, directed_rows[i].data, n_bytes, first_byte);
      if (directed_rows[i].typed) begin
        if (n_bytes != directed_rows[i].n_exp) begin
          report_mismatch($sformatf("burst length of row %0d", i), n_bytes,
                          directed_rows[i].n_exp);
        end
        if (n_bytes > 0 && first_byte !== directed_rows[i].first_exp) begin
          report_mismatch($sformatf("first byte of row %0d", i), first_byte,
                          directed_rows[i].first_exp);
        end
      end
    end

    // Let the directed stream run dry before the random part starts.
    drain_output();

    // Random stream: mostly well-formed tokens with random content; copies
    // often point just behind the write pointer so that they overlap their
    // own output. The rest is restarts and stray bytes that break framing.
    while (stream_items < 145) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        send_byte(OP_RESTART, 8'($urandom), n_bytes, first_byte);
        stream_items++;
      end else if (roll < 12) begin
        send_byte(OP_STREAM, 8'($urandom), n_bytes, first_byte);
        stream_items++;
      end else if (roll < 50) begin
        // Every eighth literal run is the longest one.
        if (lit_tokens % 8 == 0) begin
          run_len = 15;
        end else if ($urandom_range(0, 3) == 0) begin
          run_len = $urandom_range(4, 15);
        end else begin
          run_len = $urandom_range(0, 3);
        end
        lit_tokens++;
        send_byte(OP_STREAM, {4'h0, 4'(run_len)}, n_bytes, first_byte);
        stream_items++;
        for (int k = 0; k <= run_len; k++) begin
          send_byte(OP_STREAM, 8'($urandom), n_bytes, first_byte);
          stream_items++;
        end
      end else begin
        hi = 4'($urandom_range(1, 15));
        if ($urandom_range(0, 9) < 4) begin
          pos = wr_ptr_m - 12'($urandom_range(1, 24));
        end else begin
          pos = 12'($urandom);
        end
        send_byte(OP_STREAM, {hi, pos[11:8]}, n_bytes, first_byte);
        send_byte(OP_STREAM, pos[7:0], n_bytes, first_byte);
        stream_items += 2;
      end
      if (!paused && stream_items >= 72) begin
        paused = 1'b1;
        drain_output();
      end
    end

    // Wait for the last bytes, then a little longer to catch any extra ones.
    drain_output();
    repeat (40) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("** lz_ring_window_decompressor_core: PASSED **");
    end else begin
      $display("** lz_ring_window_decompressor_core: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/lzrw_pkg.sv
rtl/core/lz_ring_window_decompressor_core.sv
dv/lz_ring_window_decompressor_core_test.sv
